// ===== rtl/core/gwat_pkg.sv =====
// Shared types, constants and codes of the grey-world auto tone block.
package gwat_pkg;

  localparam int MEAN_W = 12;
  localparam int GAIN_W = 13;
  localparam int BRI_W  = 12;
  localparam int PROD_W = 25;
  localparam int ACC_W  = 36;

  typedef logic [MEAN_W-1:0]        mean_t;
  typedef logic [GAIN_W-1:0]        gain_t;
  typedef logic signed [BRI_W-1:0]  bri_t;
  typedef logic [PROD_W-1:0]        prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Q1.12 levels and clamp limits.
  localparam gain_t GAIN_ONE = 13'd4096;
  localparam gain_t GAIN_MIN = 13'd1229;
  localparam gain_t GAIN_MAX = 13'd6963;
  localparam gain_t CON_MIN  = 13'd3686;
  localparam gain_t CON_MAX  = 13'd6144;
  localparam logic [BRI_W-1:0] BRI_LIMIT = 12'd1229;
  localparam mean_t SPREAD_ONE = 12'd16;

  // Register reset values.
  localparam mean_t MIN_MEAN_RST      = 12'd64;
  localparam mean_t TARGET_LUMA_RST   = 12'd1888;
  localparam mean_t TARGET_SPREAD_RST = 12'd832;
  localparam gain_t AUTO_SAT_RST      = 13'd5120;

  // BT.601 weights scaled by 1000.
  localparam gain_t COEF_R     = 13'd299;
  localparam gain_t COEF_G     = 13'd587;
  localparam gain_t COEF_B     = 13'd114;
  localparam gain_t LUMA_SCALE = 13'd1000;

  // Brightness divisor 1000 * 255 * 16 and its double.
  localparam logic [21:0] BRI_DEN  = 22'd4080000;
  localparam logic [22:0] BRI_DEN2 = 23'd8160000;

  localparam logic [3:0] DIV_STEPS = 4'd14;
  localparam logic [3:0] BRI_STEPS = 4'd12;

  typedef enum logic [1:0] {
    CFG_MIN_MEAN      = 2'd0,
    CFG_TARGET_LUMA   = 2'd1,
    CFG_TARGET_SPREAD = 2'd2,
    CFG_AUTO_SAT      = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RED,
    ST_DIV_BLUE,
    ST_DIV_CON,
    ST_MAC,
    ST_BRI,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    TERM_RED_PROD,
    TERM_BLUE_PROD,
    TERM_RED_LUMA,
    TERM_BLUE_LUMA,
    TERM_GREEN_LUMA,
    TERM_TARGET
  } term_t;

  typedef struct packed {
    logic  stats_valid;
    mean_t mean_red;
    mean_t mean_green;
    mean_t mean_blue;
    mean_t tone_spread;
  } stats_t;

  typedef struct packed {
    gain_t red_gain_out;
    gain_t green_gain_out;
    gain_t blue_gain_out;
    logic  balance_enabled;
    gain_t saturation_out;
    gain_t contrast_out;
    bri_t  brightness_out;
    logic  applied;
  } tone_t;

  typedef struct packed {
    logic  start;
    mean_t num;
    mean_t den;
    gain_t lo;
    gain_t hi;
  } div_req_t;

  typedef struct packed {
    logic  start;
    logic  clear;
    logic  sub;
    prod_t a;
    gain_t b;
  } mac_cmd_t;

endpackage

// ===== rtl/core/gwat_stats_if.sv =====
// Handshake channel that carries one set of frame statistics.
interface gwat_stats_if;
  logic             valid;
  logic             ready;
  gwat_pkg::stats_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/gwat_tone_if.sv =====
// Handshake channel that carries one set of tone and balance results.
interface gwat_tone_if;
  logic            valid;
  logic            ready;
  gwat_pkg::tone_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/gwat_div.sv =====
// Bit-serial restoring divider giving a rounded, clamped Q1.12 ratio.
module gwat_div (
  input  logic               clk,
  input  logic               rst,
  input  gwat_pkg::div_req_t req,
  output logic               done,
  output gwat_pkg::gain_t    res
);

  logic        busy;
  logic [3:0]  cnt;
  logic [12:0] rem;
  logic [13:0] quo;
  logic        ovf;
  logic        ge;
  logic [11:0] rem_sub;
  logic [14:0] rnd;
  gwat_pkg::gain_t fin;

  always_comb begin
    ge = rem >= {1'b0, req.den};
    rem_sub = ge ? 12'(rem - {1'b0, req.den}) : rem[11:0];
    rnd = {1'b0, quo} + 15'd1;
    // The rounded ratio is (quotient + 1) / 2 of num * 8192 / den.
    if (ovf) begin
      fin = req.hi;
    end else if (rnd[14:1] > {1'b0, req.hi}) begin
      fin = req.hi;
    end else if (rnd[14:1] < {1'b0, req.lo}) begin
      fin = req.lo;
    end else begin
      fin = rnd[13:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem <= {1'b0, req.num};
        quo <= '0;
        // A ratio of two or more always lands on the upper clamp.
        ovf <= {1'b0, req.num} >= {req.den, 1'b0};
        cnt <= ({1'b0, req.num} >= {req.den, 1'b0}) ? 4'd0 : gwat_pkg::DIV_STEPS;
      end else if (busy) begin
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          res <= fin;
        end else begin
          rem <= {rem_sub, 1'b0};
          quo <= {quo[12:0], ge};
          cnt <= cnt - 4'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/gwat_mac.sv =====
// Bit-serial shift-and-add multiply-accumulate unit for the luma sum.
module gwat_mac (
  input  logic               clk,
  input  logic               rst,
  input  gwat_pkg::mac_cmd_t cmd,
  output logic               done,
  output gwat_pkg::acc_t     acc
);

  logic        busy;
  logic        sub;
  logic [35:0] a_sh;
  logic [12:0] b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        sub <= cmd.sub;
        a_sh <= 36'(cmd.a);
        b_sh <= cmd.b;
        if (cmd.clear) begin
          acc <= '0;
        end
      end else if (busy) begin
        // The multiplier runs out of set bits when the product is complete.
        if (b_sh == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (b_sh[0]) begin
            acc <= sub ? acc - $signed(a_sh) : acc + $signed(a_sh);
          end
          a_sh <= {a_sh[34:0], 1'b0};
          b_sh <= {1'b0, b_sh[12:1]};
        end
      end
    end
  end

endmodule

// ===== rtl/core/gwat_bri.sv =====
// Bit-serial division of the luma error by 255 * 1000 * 16 with rounding and clamp.
module gwat_bri (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  gwat_pkg::acc_t diff,
  output logic           done,
  output gwat_pkg::bri_t bri
);

  logic        busy;
  logic        neg;
  logic [3:0]  cnt;
  logic [36:0] rem;
  logic [33:0] dsh;
  logic [11:0] quo;
  logic [36:0] mag2;
  logic [36:0] ofs;
  logic        ge;
  logic [11:0] mag;

  always_comb begin
    // Twice the magnitude plus the divisor, so that the floor rounds half up.
    mag2 = diff[35] ? {~diff, 1'b0} : {diff, 1'b0};
    ofs = diff[35] ? 37'(gwat_pkg::BRI_DEN) + 37'd2 : 37'(gwat_pkg::BRI_DEN);
    ge = rem >= {3'b0, dsh};
    mag = (quo > gwat_pkg::BRI_LIMIT) ? gwat_pkg::BRI_LIMIT : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg <= diff[35];
        rem <= mag2 + ofs;
        dsh <= {gwat_pkg::BRI_DEN2, 11'b0};
        quo <= '0;
        cnt <= gwat_pkg::BRI_STEPS;
      end else if (busy) begin
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          bri <= neg ? -$signed(mag) : $signed(mag);
        end else begin
          // A set top quotient bit already means the limit is reached.
          if (ge) begin
            rem <= rem - {3'b0, dsh};
          end
          quo <= {quo[10:0], ge};
          dsh <= {1'b0, dsh[33:1]};
          cnt <= cnt - 4'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/grey_world_auto_tone.sv =====
// Top level of the grey-world white balance and auto tone block.
//
// One statistics item enters on the stats channel (valid/ready) and one
// result item leaves on the result channel for every item taken. Registers
// are written through cfg_we, cfg_index and cfg_data; the user must write
// them only while the block is idle, which the block itself does not enforce.
// An unusable item goes straight to the last state. A usable item runs
// through the red and blue gain divisions and the contrast division, each
// ending early when the ratio is two or more; the contrast division is
// skipped when the spread is at most 1.0. The six shift-and-add passes of
// the shared multiply-accumulate unit for the luma each step through the
// multiplier bits until no set bit is left, then the brightness divide runs.
// One item is worked on at a time; the next is taken as soon as the result
// sits in the output register, even if the receiver has not yet taken it.
// While the receiver stalls, the result is held and a finished item waits in
// the last state until the register frees up.
// Reset (rst, synchronous) returns the sequencer to idle, clears the result
// valid, restores the register defaults and sets unity gains, balance
// disabled and zero brightness.
module grey_world_auto_tone (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_data,
  gwat_stats_if.sink          stats,
  gwat_tone_if.source         result
);

  gwat_pkg::mean_t min_usable_mean;
  gwat_pkg::mean_t target_luma;
  gwat_pkg::mean_t target_spread;
  gwat_pkg::gain_t auto_saturation;

  gwat_pkg::gain_t red_gain;
  gwat_pkg::gain_t green_gain;
  gwat_pkg::gain_t blue_gain;
  logic            enable_flag;
  gwat_pkg::gain_t saturation_level;
  gwat_pkg::gain_t contrast_level;
  gwat_pkg::bri_t  brightness_offset;
  logic            applied;

  gwat_pkg::mean_t mean_r;
  gwat_pkg::mean_t mean_g;
  gwat_pkg::mean_t mean_b;
  gwat_pkg::mean_t spread;
  gwat_pkg::prod_t t_red;
  gwat_pkg::prod_t t_blue;

  gwat_pkg::state_t state;
  gwat_pkg::state_t state_next;
  gwat_pkg::term_t  term;
  gwat_pkg::term_t  term_next;
  logic             issued;

  gwat_pkg::div_req_t div_req;
  logic               div_done;
  gwat_pkg::gain_t    div_res;
  gwat_pkg::mac_cmd_t mac_cmd;
  logic               mac_done;
  gwat_pkg::acc_t     mac_acc;
  logic               bri_start;
  logic               bri_done;
  gwat_pkg::bri_t     bri_res;

  logic            accept;
  logic            usable;
  logic            load_res;
  gwat_pkg::tone_t res;
  logic            res_valid;

  gwat_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .res  (div_res)
  );

  gwat_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .done (mac_done),
    .acc  (mac_acc)
  );

  gwat_bri u_bri (
    .clk   (clk),
    .rst   (rst),
    .start (bri_start),
    .diff  (mac_acc),
    .done  (bri_done),
    .bri   (bri_res)
  );

  assign accept = stats.valid && stats.ready;
  assign usable = stats.data.stats_valid &&
                  (stats.data.mean_red > min_usable_mean) &&
                  (stats.data.mean_green > min_usable_mean) &&
                  (stats.data.mean_blue > min_usable_mean);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      gwat_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = usable ? gwat_pkg::ST_DIV_RED : gwat_pkg::ST_DONE;
        end
      end
      gwat_pkg::ST_DIV_RED: begin
        if (div_done) begin
          state_next = gwat_pkg::ST_DIV_BLUE;
        end
      end
      gwat_pkg::ST_DIV_BLUE: begin
        if (div_done) begin
          state_next = (spread > gwat_pkg::SPREAD_ONE) ? gwat_pkg::ST_DIV_CON :
                                                         gwat_pkg::ST_MAC;
        end
      end
      gwat_pkg::ST_DIV_CON: begin
        if (div_done) begin
          state_next = gwat_pkg::ST_MAC;
        end
      end
      gwat_pkg::ST_MAC: begin
        if (mac_done && term == gwat_pkg::TERM_TARGET) begin
          state_next = gwat_pkg::ST_BRI;
        end
      end
      gwat_pkg::ST_BRI: begin
        if (bri_done) begin
          state_next = gwat_pkg::ST_DONE;
        end
      end
      gwat_pkg::ST_DONE: begin
        if (!res_valid || result.ready) begin
          state_next = gwat_pkg::ST_IDLE;
        end
      end
      default: state_next = gwat_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    stats.ready = (state == gwat_pkg::ST_IDLE);
    load_res = (state == gwat_pkg::ST_DONE) && (!res_valid || result.ready);
    bri_start = (state == gwat_pkg::ST_BRI) && !issued;

    div_req.start = 1'b0;
    div_req.num = mean_g;
    div_req.den = mean_r;
    div_req.lo = gwat_pkg::GAIN_MIN;
    div_req.hi = gwat_pkg::GAIN_MAX;
    case (state)
      gwat_pkg::ST_DIV_RED: begin
        div_req.start = !issued;
      end
      gwat_pkg::ST_DIV_BLUE: begin
        div_req.start = !issued;
        div_req.den = mean_b;
      end
      gwat_pkg::ST_DIV_CON: begin
        div_req.start = !issued;
        div_req.num = target_spread;
        div_req.den = spread;
        div_req.lo = gwat_pkg::CON_MIN;
        div_req.hi = gwat_pkg::CON_MAX;
      end
      default: ;
    endcase

    mac_cmd.start = (state == gwat_pkg::ST_MAC) && !issued;
    mac_cmd.clear = 1'b0;
    mac_cmd.sub = 1'b1;
    mac_cmd.a = t_red;
    mac_cmd.b = gwat_pkg::COEF_R;
    // The accumulator ends at target * 4096000 minus the weighted luma.
    case (term)
      gwat_pkg::TERM_RED_PROD: begin
        mac_cmd.clear = 1'b1;
        mac_cmd.sub = 1'b0;
        mac_cmd.a = gwat_pkg::PROD_W'(mean_r);
        mac_cmd.b = red_gain;
      end
      gwat_pkg::TERM_BLUE_PROD: begin
        mac_cmd.clear = 1'b1;
        mac_cmd.sub = 1'b0;
        mac_cmd.a = gwat_pkg::PROD_W'(mean_b);
        mac_cmd.b = blue_gain;
      end
      gwat_pkg::TERM_RED_LUMA: begin
        mac_cmd.clear = 1'b1;
      end
      gwat_pkg::TERM_BLUE_LUMA: begin
        mac_cmd.a = t_blue;
        mac_cmd.b = gwat_pkg::COEF_B;
      end
      gwat_pkg::TERM_GREEN_LUMA: begin
        mac_cmd.a = {1'b0, mean_g, 12'b0};
        mac_cmd.b = gwat_pkg::COEF_G;
      end
      gwat_pkg::TERM_TARGET: begin
        mac_cmd.sub = 1'b0;
        mac_cmd.a = {1'b0, target_luma, 12'b0};
        mac_cmd.b = gwat_pkg::LUMA_SCALE;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (term)
      gwat_pkg::TERM_RED_PROD:   term_next = gwat_pkg::TERM_BLUE_PROD;
      gwat_pkg::TERM_BLUE_PROD:  term_next = gwat_pkg::TERM_RED_LUMA;
      gwat_pkg::TERM_RED_LUMA:   term_next = gwat_pkg::TERM_BLUE_LUMA;
      gwat_pkg::TERM_BLUE_LUMA:  term_next = gwat_pkg::TERM_GREEN_LUMA;
      gwat_pkg::TERM_GREEN_LUMA: term_next = gwat_pkg::TERM_TARGET;
      default:                   term_next = gwat_pkg::TERM_RED_PROD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gwat_pkg::ST_IDLE;
      term <= gwat_pkg::TERM_RED_PROD;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (state != state_next || mac_done) begin
        issued <= 1'b0;
      end else if (div_req.start || mac_cmd.start || bri_start) begin
        issued <= 1'b1;
      end
      if (accept) begin
        term <= gwat_pkg::TERM_RED_PROD;
      end else if (mac_done) begin
        term <= term_next;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_usable_mean <= gwat_pkg::MIN_MEAN_RST;
      target_luma <= gwat_pkg::TARGET_LUMA_RST;
      target_spread <= gwat_pkg::TARGET_SPREAD_RST;
      auto_saturation <= gwat_pkg::AUTO_SAT_RST;
    end else if (cfg_we) begin
      case (gwat_pkg::cfg_idx_t'(cfg_index))
        gwat_pkg::CFG_MIN_MEAN:      min_usable_mean <= cfg_data[11:0];
        gwat_pkg::CFG_TARGET_LUMA:   target_luma <= cfg_data[11:0];
        gwat_pkg::CFG_TARGET_SPREAD: target_spread <= cfg_data[11:0];
        gwat_pkg::CFG_AUTO_SAT:      auto_saturation <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured statistics and the partial products of the luma sum.
  always_ff @(posedge clk) begin
    if (accept) begin
      mean_r <= stats.data.mean_red;
      mean_g <= stats.data.mean_green;
      mean_b <= stats.data.mean_blue;
      spread <= stats.data.tone_spread;
    end
    if (mac_done && term == gwat_pkg::TERM_RED_PROD) begin
      t_red <= mac_acc[gwat_pkg::PROD_W-1:0];
    end
    if (mac_done && term == gwat_pkg::TERM_BLUE_PROD) begin
      t_blue <= mac_acc[gwat_pkg::PROD_W-1:0];
    end
  end

  // Stored tone and balance values.
  always_ff @(posedge clk) begin
    if (rst) begin
      red_gain <= gwat_pkg::GAIN_ONE;
      green_gain <= gwat_pkg::GAIN_ONE;
      blue_gain <= gwat_pkg::GAIN_ONE;
      enable_flag <= 1'b0;
      saturation_level <= gwat_pkg::GAIN_ONE;
      contrast_level <= gwat_pkg::GAIN_ONE;
      brightness_offset <= '0;
      applied <= 1'b0;
    end else begin
      if (accept) begin
        applied <= usable;
        if (usable) begin
          green_gain <= gwat_pkg::GAIN_ONE;
          enable_flag <= 1'b1;
          saturation_level <= auto_saturation;
          contrast_level <= gwat_pkg::GAIN_ONE;
        end
      end
      if (div_done) begin
        case (state)
          gwat_pkg::ST_DIV_RED:  red_gain <= div_res;
          gwat_pkg::ST_DIV_BLUE: blue_gain <= div_res;
          gwat_pkg::ST_DIV_CON:  contrast_level <= div_res;
          default: ;
        endcase
      end
      if (bri_done) begin
        brightness_offset <= bri_res;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (load_res) begin
      res.red_gain_out <= red_gain;
      res.green_gain_out <= green_gain;
      res.blue_gain_out <= blue_gain;
      res.balance_enabled <= enable_flag;
      res.saturation_out <= saturation_level;
      res.contrast_out <= contrast_level;
      res.brightness_out <= brightness_offset;
      res.applied <= applied;
    end
  end

  assign result.valid = res_valid;
  assign result.data = res;

endmodule

// ===== dv/grey_world_auto_tone_tb.sv =====
// Self-checking testbench for the grey-world white balance and auto tone block.
`timescale 1ns / 100ps

module grey_world_auto_tone_tb;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;
  localparam longint LUMA_DEN = 64'd4080000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [12:0] cfg_data;

  gwat_stats_if stats_ch ();
  gwat_tone_if tone_ch ();

  grey_world_auto_tone dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stats     (stats_ch),
    .result    (tone_ch)
  );

  always #2 clk = ~clk;

  // Register copies as the block should hold them.
  gwat_pkg::mean_t cfg_min_mean = gwat_pkg::MIN_MEAN_RST;
  gwat_pkg::mean_t cfg_target_luma = gwat_pkg::TARGET_LUMA_RST;
  gwat_pkg::mean_t cfg_target_spread = gwat_pkg::TARGET_SPREAD_RST;
  gwat_pkg::gain_t cfg_auto_sat = gwat_pkg::AUTO_SAT_RST;

  // Stored tone state as the block should hold it.
  gwat_pkg::gain_t wb_red = gwat_pkg::GAIN_ONE;
  gwat_pkg::gain_t wb_green = gwat_pkg::GAIN_ONE;
  gwat_pkg::gain_t wb_blue = gwat_pkg::GAIN_ONE;
  logic wb_enabled = 1'b0;
  gwat_pkg::gain_t sat_level = gwat_pkg::GAIN_ONE;
  gwat_pkg::gain_t con_level = gwat_pkg::GAIN_ONE;
  gwat_pkg::bri_t bri_level = '0;

  gwat_pkg::stats_t stats_backlog[$];
  gwat_pkg::tone_t tone_expected[$];

  bit stats_took;
  bit tone_took;
  int idle_cycles = 0;
  int send_gap = 0;
  int hold_left = 0;
  int calm_left = 0;
  int mismatch_count = 0;
  int n_stats = 0;
  int n_usable = 0;
  int n_tones = 0;
  int n_writes = 0;

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Mostly short pauses, a few long ones, and now and then a calm stretch with none.
  function automatic int idle_gap();
    int pick;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 24);
    return $urandom_range(40, 200);
  endfunction

  function automatic longint unsigned scaled_ratio(longint unsigned num, longint unsigned den);
    return ((num << 13) + den) / (den * 2);
  endfunction

  function automatic gwat_pkg::gain_t clamp_q12(longint unsigned v, gwat_pkg::gain_t lo,
                                                gwat_pkg::gain_t hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v[gwat_pkg::GAIN_W-1:0];
  endfunction

  // Works out the result of one statistics item and updates the stored state.
  function automatic gwat_pkg::tone_t next_tone(gwat_pkg::stats_t s);
    gwat_pkg::tone_t t;
    longint r, g, b, rg, bg, luma, diff, mag, q;
    r = s.mean_red;
    g = s.mean_green;
    b = s.mean_blue;
    t.applied = 1'b0;
    if (s.stats_valid && s.mean_red > cfg_min_mean && s.mean_green > cfg_min_mean &&
        s.mean_blue > cfg_min_mean) begin
      wb_red = clamp_q12(scaled_ratio(g, r), gwat_pkg::GAIN_MIN, gwat_pkg::GAIN_MAX);
      wb_green = gwat_pkg::GAIN_ONE;
      wb_blue = clamp_q12(scaled_ratio(g, b), gwat_pkg::GAIN_MIN, gwat_pkg::GAIN_MAX);
      wb_enabled = 1'b1;
      sat_level = cfg_auto_sat;
      if (s.tone_spread > gwat_pkg::SPREAD_ONE) begin
        con_level = clamp_q12(scaled_ratio(cfg_target_spread, s.tone_spread),
                              gwat_pkg::CON_MIN, gwat_pkg::CON_MAX);
      end else begin
        con_level = gwat_pkg::GAIN_ONE;
      end
      // Luma from the clamped gains, kept scaled by 1000 in Q13.12.
      rg = wb_red;
      bg = wb_blue;
      luma = 299 * rg * r + 587 * g * 4096 + 114 * bg * b;
      diff = longint'(cfg_target_luma) * 4096 * 1000 - luma;
      mag = (diff < 0) ? -diff : diff;
      q = (mag * 2 + LUMA_DEN) / (LUMA_DEN * 2);
      if (q > gwat_pkg::BRI_LIMIT) q = gwat_pkg::BRI_LIMIT;
      if (diff < 0) q = -q;
      bri_level = q[gwat_pkg::BRI_W-1:0];
      t.applied = 1'b1;
      n_usable++;
    end
    t.red_gain_out = wb_red;
    t.green_gain_out = wb_green;
    t.blue_gain_out = wb_blue;
    t.balance_enabled = wb_enabled;
    t.saturation_out = sat_level;
    t.contrast_out = con_level;
    t.brightness_out = bri_level;
    return t;
  endfunction

  task automatic check_field(string name, logic [12:0] got, logic [12:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d", n_tones, name, got, want));
    end
  endtask

  task automatic compare_tone(gwat_pkg::tone_t got, gwat_pkg::tone_t want);
    check_field("red_gain_out", got.red_gain_out, want.red_gain_out);
    check_field("green_gain_out", got.green_gain_out, want.green_gain_out);
    check_field("blue_gain_out", got.blue_gain_out, want.blue_gain_out);
    check_field("balance_enabled", 13'(got.balance_enabled), 13'(want.balance_enabled));
    check_field("saturation_out", got.saturation_out, want.saturation_out);
    check_field("contrast_out", got.contrast_out, want.contrast_out);
    check_field("brightness_out", 13'(got.brightness_out), 13'(want.brightness_out));
    check_field("applied", 13'(got.applied), 13'(want.applied));
  endtask

  // Sampling side: predicts on each accepted statistics item, checks each result item.
  always @(posedge clk) begin
    gwat_pkg::tone_t want;
    if (rst) begin
      stats_took = 1'b0;
      tone_took = 1'b0;
      idle_cycles = 0;
    end else begin
      stats_took = stats_ch.valid && stats_ch.ready;
      tone_took = tone_ch.valid && tone_ch.ready;
      if (tone_took) begin
        if (tone_expected.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", n_tones));
        end else begin
          want = tone_expected.pop_front();
          compare_tone(tone_ch.data, want);
        end
        n_tones++;
      end
      if (stats_took) begin
        tone_expected.push_back(next_tone(stats_ch.data));
        n_stats++;
      end
      idle_cycles = (stats_took || tone_took) ? 0 : idle_cycles + 1;
    end
  end

  // Statistics sender: one item at a time from the backlog, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      stats_ch.valid <= 1'b0;
    end else if (!stats_ch.valid || stats_took) begin
      if (send_gap != 0) begin
        send_gap--;
        stats_ch.valid <= 1'b0;
      end else if (stats_backlog.size() != 0) begin
        stats_ch.data <= stats_backlog.pop_front();
        stats_ch.valid <= 1'b1;
        send_gap = idle_gap();
      end else begin
        stats_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls after some items and at random moments.
  always @(negedge clk) begin
    if (rst) begin
      tone_ch.ready <= 1'b0;
    end else begin
      if (hold_left == 0 && (tone_took || $urandom_range(0, 15) == 0)) begin
        hold_left = idle_gap();
      end
      if (hold_left != 0) begin
        hold_left--;
        tone_ch.ready <= 1'b0;
      end else begin
        tone_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(gwat_pkg::cfg_idx_t idx, logic [12:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      gwat_pkg::CFG_MIN_MEAN: cfg_min_mean = value[gwat_pkg::MEAN_W-1:0];
      gwat_pkg::CFG_TARGET_LUMA: cfg_target_luma = value[gwat_pkg::MEAN_W-1:0];
      gwat_pkg::CFG_TARGET_SPREAD: cfg_target_spread = value[gwat_pkg::MEAN_W-1:0];
      gwat_pkg::CFG_AUTO_SAT: cfg_auto_sat = value;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_stats(logic v, int unsigned r, int unsigned g, int unsigned b,
                            int unsigned sp);
    gwat_pkg::stats_t s;
    s.stats_valid = v;
    s.mean_red = r[gwat_pkg::MEAN_W-1:0];
    s.mean_green = g[gwat_pkg::MEAN_W-1:0];
    s.mean_blue = b[gwat_pkg::MEAN_W-1:0];
    s.tone_spread = sp[gwat_pkg::MEAN_W-1:0];
    stats_backlog.push_back(s);
  endtask

  task automatic wait_idle();
    while (stats_backlog.size() != 0 || stats_ch.valid || tone_expected.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic int unsigned usable_mean(int unsigned lo);
    int unsigned v;
    case ($urandom_range(0, 7))
      0: v = lo;
      1: v = 4095;
      2: v = lo + $urandom_range(0, 15);
      default: v = $urandom_range(lo, 4095);
    endcase
    return (v > 4095) ? 4095 : v;
  endfunction

  // Near-grey channel around a base mean, kept in the usable range.
  function automatic int unsigned grey_mean(int unsigned base, int unsigned lo);
    int v;
    v = int'(base) + $urandom_range(0, base) - int'(base / 2);
    if (v < int'(lo)) v = lo;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  task automatic push_random_stats();
    int unsigned lo, pick, base, r, g, b, sp;
    logic v;
    lo = cfg_min_mean + 1;
    pick = $urandom_range(0, 99);
    if (pick < 80 && cfg_min_mean != 12'hFFF) begin
      v = 1'b1;
      if (pick < 35) begin
        base = usable_mean(lo);
        r = grey_mean(base, lo);
        g = grey_mean(base, lo);
        b = grey_mean(base, lo);
      end else begin
        r = usable_mean(lo);
        g = usable_mean(lo);
        b = usable_mean(lo);
      end
    end else begin
      v = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 4095);
      g = $urandom_range(0, 4095);
      b = $urandom_range(0, 4095);
      // Some of the noise sits exactly on the usability threshold.
      if (pick < 90) begin
        case ($urandom_range(0, 2))
          0: r = cfg_min_mean;
          1: g = cfg_min_mean;
          default: b = cfg_min_mean;
        endcase
      end
    end
    case ($urandom_range(0, 3))
      0: sp = $urandom_range(0, 24);
      default: sp = $urandom_range(0, 4095);
    endcase
    push_stats(v, r, g, b, sp);
  endtask

  initial begin
    int unsigned p, k;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stats_ch.valid = 1'b0;
    stats_ch.data = '0;
    tone_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Register defaults: flag low, threshold edge, gain and contrast clamps, brightness limits.
    push_stats(1'b0, 4095, 4095, 4095, 4095);
    push_stats(1'b1, 64, 2000, 2000, 832);
    push_stats(1'b1, 2048, 2048, 2048, 832);
    push_stats(1'b1, 65, 4095, 65, 0);
    push_stats(1'b1, 4095, 65, 4095, 16);
    push_stats(1'b1, 1000, 1500, 700, 17);
    push_stats(1'b1, 1000, 1000, 1000, 4095);
    push_stats(1'b1, 4095, 4095, 4095, 1000);
    push_stats(1'b1, 65, 65, 65, 1000);
    push_stats(1'b1, 1888, 1888, 1888, 832);
    push_stats(1'b1, 0, 0, 0, 0);
    push_stats(1'b0, 2048, 2048, 2048, 832);
    wait_idle();

    // Low extremes; the upper bit of the 12-bit registers must be dropped.
    write_reg(gwat_pkg::CFG_MIN_MEAN, 13'h1000);
    write_reg(gwat_pkg::CFG_TARGET_LUMA, 13'h0000);
    write_reg(gwat_pkg::CFG_TARGET_SPREAD, 13'h1000);
    write_reg(gwat_pkg::CFG_AUTO_SAT, 13'h0000);
    push_stats(1'b1, 0, 100, 100, 50);
    push_stats(1'b1, 1, 1, 1, 17);
    push_stats(1'b1, 4095, 1, 4095, 4095);
    push_stats(1'b1, 1, 4095, 1, 2);
    wait_idle();

    // High extremes.
    write_reg(gwat_pkg::CFG_MIN_MEAN, 13'h0FFE);
    write_reg(gwat_pkg::CFG_TARGET_LUMA, 13'h1FFF);
    write_reg(gwat_pkg::CFG_TARGET_SPREAD, 13'h1FFF);
    write_reg(gwat_pkg::CFG_AUTO_SAT, 13'h1FFF);
    push_stats(1'b1, 4095, 4095, 4095, 17);
    push_stats(1'b1, 4094, 4095, 4095, 4095);
    push_stats(1'b1, 4095, 4095, 4095, 4095);
    wait_idle();

    for (p = 0; p < 8; p++) begin
      if (p == 0) begin
        write_reg(gwat_pkg::CFG_MIN_MEAN, 13'(gwat_pkg::MIN_MEAN_RST));
        write_reg(gwat_pkg::CFG_TARGET_LUMA, 13'(gwat_pkg::TARGET_LUMA_RST));
        write_reg(gwat_pkg::CFG_TARGET_SPREAD, 13'(gwat_pkg::TARGET_SPREAD_RST));
        write_reg(gwat_pkg::CFG_AUTO_SAT, gwat_pkg::AUTO_SAT_RST);
      end else begin
        case ($urandom_range(0, 3))
          0: write_reg(gwat_pkg::CFG_MIN_MEAN, {1'($urandom_range(0, 1)), 12'd0});
          1: write_reg(gwat_pkg::CFG_MIN_MEAN, 13'($urandom_range(1, 128)));
          2: write_reg(gwat_pkg::CFG_MIN_MEAN, 13'($urandom_range(0, 2000)));
          default: write_reg(gwat_pkg::CFG_MIN_MEAN, 13'($urandom_range(0, 8191)));
        endcase
        write_reg(gwat_pkg::CFG_TARGET_LUMA, 13'($urandom_range(0, 8191)));
        write_reg(gwat_pkg::CFG_TARGET_SPREAD, 13'($urandom_range(0, 8191)));
        write_reg(gwat_pkg::CFG_AUTO_SAT, 13'($urandom_range(0, 8191)));
      end
      for (k = 0; k < 210; k++) begin
        push_random_stats();
      end
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d statistics items (%0d usable) across %0d register writes.",
             n_stats, n_usable, n_writes);
    $display("Checked %0d result items, %0d mismatches.", n_tones, mismatch_count);
    if (mismatch_count == 0) begin
      $display("grey_world_auto_tone test passed");
    end else begin
      $display("grey_world_auto_tone test failed");
    end
    $finish;
  end

  // Ends the run when neither channel has moved for too long.
  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
    $display("grey_world_auto_tone test failed");
    $finish;
  end

endmodule
